FILE: sv/load_stall_detector_assert.svh
// ============================================================================
// load_stall_detector_assert.svh
// Assertion macros used by the load stall detector core (ldsd_core).
// ============================================================================
`ifndef LOAD_STALL_DETECTOR_ASSERT_SVH
`define LOAD_STALL_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while the synchronous reset is low
`define LSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while the synchronous reset is low
`define LSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ldsd_pkg.sv
// ============================================================================
// ldsd_pkg
// Types and constants of the load stall detector.
// ============================================================================
package ldsd_pkg;

    localparam int LOAD_W      = 10;
    localparam int VEL_W       = 16;
    localparam int SLOPE_W     = 16;
    localparam int MARGIN_W    = 10;
    localparam int CNT_W       = 8;
    localparam int SLOPE_FRAC  = 8;
    localparam int PROD_W      = SLOPE_W + VEL_W;
    localparam int SCALED_W    = PROD_W - SLOPE_FRAC;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    // Register reset values
    localparam logic [SLOPE_W-1:0] SLOPE_RST     = 16'd256;
    localparam logic [CNT_W-1:0]   RUN_LIMIT_RST = 8'd3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMOOTH_EN    = 3'd0,
        CFG_SLOPE        = 3'd1,
        CFG_STALL_MARGIN = 3'd2,
        CFG_GRIP_MARGIN  = 3'd3,
        CFG_RUN_LIMIT    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic                smooth_en;
        logic [SLOPE_W-1:0]  slope;
        logic [MARGIN_W-1:0] stall_margin;
        logic [MARGIN_W-1:0] grip_margin;
        logic [CNT_W-1:0]    run_limit;
    } t_cfg;

    // Sample held in the input register, threshold product already scaled
    typedef struct packed {
        logic [LOAD_W-1:0]   load;
        logic                grip;
        logic [SCALED_W-1:0] scaled;
    } t_in_item;

    typedef struct packed {
        logic             stop;
        logic             stall;
        logic [CNT_W-1:0] count;
    } t_result;

endpackage

FILE: sv/ldsd_cfg.sv
// ============================================================================
// ldsd_cfg
// Configuration register file, written through a plain write port.
// ============================================================================
module ldsd_cfg
    import ldsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.smooth_en    <= 1'b0;
            r_cfg.slope        <= SLOPE_RST;
            r_cfg.stall_margin <= '0;
            r_cfg.grip_margin  <= '0;
            r_cfg.run_limit    <= RUN_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SMOOTH_EN:    r_cfg.smooth_en    <= i_cfg_wdata[0];
                CFG_SLOPE:        r_cfg.slope        <= i_cfg_wdata[SLOPE_W-1:0];
                CFG_STALL_MARGIN: r_cfg.stall_margin <= i_cfg_wdata[MARGIN_W-1:0];
                CFG_GRIP_MARGIN:  r_cfg.grip_margin  <= i_cfg_wdata[MARGIN_W-1:0];
                CFG_RUN_LIMIT:    r_cfg.run_limit    <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/ldsd_in.sv
// ============================================================================
// ldsd_in
// Input register; scales velocity by the threshold slope on capture.
// ============================================================================
module ldsd_in
    import ldsd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [LOAD_W-1:0]  i_load,
    input  logic [VEL_W-1:0]   i_vel,
    input  logic               i_grip,
    input  logic [SLOPE_W-1:0] i_slope,
    output logic               o_valid,
    output t_in_item           o_item,
    input  logic               i_take
);

    logic              r_valid;
    t_in_item          r_item;
    logic [PROD_W-1:0] w_prod;

    // Room when empty or when the core takes the held sample this cycle
    assign o_ready = !r_valid || i_take;

    // slope is Q8.8: drop the fraction bits of the product
    assign w_prod = PROD_W'(i_slope) * PROD_W'(i_vel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.load   <= i_load;
            r_item.grip   <= i_grip;
            r_item.scaled <= w_prod[PROD_W-1:SLOPE_FRAC];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: sv/ldsd_core.sv
// ============================================================================
// ldsd_core
// EMA, threshold compare, run counter and the result register.
// ============================================================================
`include "load_stall_detector_assert.svh"

module ldsd_core
    import ldsd_pkg::*;
#(
    parameter int SMOOTH_FRAC_BITS = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_take,
    output logic     o_valid,
    output t_result  o_result,
    input  logic     i_ready
);

    localparam int SMOOTH_W = LOAD_W + SMOOTH_FRAC_BITS;
    localparam int SUM_W    = SMOOTH_W + 2;

    logic [SMOOTH_W-1:0] r_smooth;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_grip_lat;
    logic                r_stall;
    logic                r_out_valid;
    t_result             r_out;

    logic [SUM_W-1:0]    w_sum;
    logic [SMOOTH_W-1:0] n_smooth;
    logic [LOAD_W-1:0]   w_cmp;
    logic                n_grip_lat;
    logic [MARGIN_W-1:0] w_margin;
    logic [LOAD_W:0]     w_lhs;
    logic                w_below;
    logic [CNT_W-1:0]    w_cnt_inc;
    logic                w_hit;
    logic                w_stop;
    logic [CNT_W-1:0]    n_cnt;
    logic                n_stall;

    // Result register frees up when empty or when the receiver takes it
    assign o_take = i_valid && (!r_out_valid || i_ready);

    // EMA with alpha 1/4: (sample << F + 3 * avg) / 4
    always_comb begin
        w_sum    = (SUM_W'(i_item.load) << SMOOTH_FRAC_BITS)
                 + (SUM_W'(r_smooth) << 1) + SUM_W'(r_smooth);
        n_smooth = w_sum[SUM_W-1:2];
        w_cmp    = i_cfg.smooth_en ? n_smooth[SMOOTH_W-1:SMOOTH_FRAC_BITS]
                                   : i_item.load;
    end

    // Threshold compare: cmp < scaled - margin, done as cmp + margin < scaled
    always_comb begin
        n_grip_lat = r_grip_lat || (i_cfg.smooth_en && i_item.grip);
        w_margin   = n_grip_lat ? i_cfg.grip_margin : i_cfg.stall_margin;
        w_lhs      = (LOAD_W + 1)'(w_cmp) + (LOAD_W + 1)'(w_margin);
        w_below    = SCALED_W'(w_lhs) < i_item.scaled;
    end

    // Run counter; a completed run restarts from zero
    always_comb begin
        w_cnt_inc = r_cnt + 1'b1;
        w_hit     = w_cnt_inc >= i_cfg.run_limit;
        w_stop    = w_below && w_hit;
        n_cnt     = (w_below && !w_hit) ? w_cnt_inc : '0;
        n_stall   = r_stall || w_stop;
    end

    // Detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth   <= '0;
            r_cnt      <= '0;
            r_grip_lat <= 1'b0;
            r_stall    <= 1'b0;
        end else if (o_take) begin
            if (i_cfg.smooth_en) begin
                r_smooth <= n_smooth;
            end
            r_cnt      <= n_cnt;
            r_grip_lat <= n_grip_lat;
            r_stall    <= n_stall;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out.stop  <= w_stop;
            r_out.stall <= n_stall;
            r_out.count <= n_cnt;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Checks
    `LSD_ASSERT_NEXT(a_stall_sticky, i_clk, i_rst_n, r_stall, r_stall,
        "stall latch cleared without reset")
    `LSD_ASSERT_NEXT(a_grip_sticky, i_clk, i_rst_n, r_grip_lat, r_grip_lat,
        "grip margin latch cleared without reset")
    `LSD_ASSERT_NOW(a_stop_flags, i_clk, i_rst_n, r_out_valid && r_out.stop,
        r_out.stall && (r_out.count == '0), "stop result without stall flag or zero count")
    `LSD_ASSERT_NEXT(a_high_clears, i_clk, i_rst_n, o_take && !w_below,
        (r_cnt == '0) && (r_out.count == '0), "sample at threshold did not clear run")

endmodule

FILE: sv/load_stall_detector.sv
// ============================================================================
// load_stall_detector
// Motor load stall detector with optional EMA smoothing of the load sample.
//
// Usage:
//   Slave stream: one load sample per transfer, tdata carries load_sample and
//   velocity, tuser carries grip_mode. Master stream: one result per sample,
//   tdata carries stop_request, sticky_stall and low_run_count.
//   Configuration registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_wdata; the user must write them only while no sample is in
//   flight, which the block itself does not enforce. A sample passes the
//   input register, then the result register. Throughput: one sample per
//   clock while the result stream takes results; the velocity product is
//   taken when the sample is captured, and the compare/count step runs as the sample enters the result register.
//   Reset (synchronous, active low) clears the EMA, the run counter, the grip
//   margin latch, the sticky stall flag and both stream registers, and loads
//   register defaults. When the receiver stalls, the result holds in the
//   output register and one more sample waits in the input register; then
//   s_axis_tready drops until the result is taken.
// ============================================================================
module load_stall_detector
    import ldsd_pkg::*;
#(
    parameter int SMOOTH_FRAC_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // sample stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [9:0] load_sample, [25:10] velocity
    input  logic                   s_axis_tuser,  // [0] grip_mode
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [0] stop_request, [1] sticky_stall,
                                                  // [9:2] low_run_count
);

    t_cfg     w_cfg;
    logic     w_in_valid;
    t_in_item w_in_item;
    logic     w_take;
    t_result  w_result;

    ldsd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    ldsd_in u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_load  (s_axis_tdata[LOAD_W-1:0]),
        .i_vel   (s_axis_tdata[LOAD_W+VEL_W-1:LOAD_W]),
        .i_grip  (s_axis_tuser),
        .i_slope (w_cfg.slope),
        .o_valid (w_in_valid),
        .o_item  (w_in_item),
        .i_take  (w_take)
    );

    ldsd_core #(
        .SMOOTH_FRAC_BITS (SMOOTH_FRAC_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (w_in_valid),
        .i_item   (w_in_item),
        .o_take   (w_take),
        .o_valid  (m_axis_tvalid),
        .o_result (w_result),
        .i_ready  (m_axis_tready)
    );

    // Pack the result, zero filled to whole bytes
    assign m_axis_tdata = OUT_TDATA_W'({w_result.count, w_result.stall, w_result.stop});

endmodule

FILE: verif/load_stall_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_stall_detector_test
// Self-checking bench for the load stall detector. A scoreboard class keeps
// its own copy of the registers, the EMA, the run counter and the two
// latches, predicts one result per accepted sample and checks every result
// transfer in order. A short directed run hits the threshold boundaries,
// negative thresholds, zero and unit run limits, and grip mode with smoothing
// off. Random phases then apply burst-shaped sample streams around the
// velocity knee under varying register settings and random stalls on both
// streams.
// ----------------------------------------------------------------------------
module load_stall_detector_test;
    import ldsd_pkg::*;

    localparam int EMA_FRAC     = 8;
    localparam int EMA_W        = LOAD_W + EMA_FRAC;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 525;

    // Predicts results of the detector and checks them in arrival order
    class stall_tracker;
        t_cfg             regs;
        logic [EMA_W-1:0] ema;
        logic [CNT_W-1:0] run_cnt;
        bit               grip_latched;
        bit               stall_seen;
        t_result          expected_results[$];
        int               mismatches;

        function new();
            regs.smooth_en    = 1'b0;
            regs.slope        = SLOPE_RST;
            regs.stall_margin = '0;
            regs.grip_margin  = '0;
            regs.run_limit    = RUN_LIMIT_RST;
            ema               = '0;
            run_cnt           = '0;
            grip_latched      = 1'b0;
            stall_seen        = 1'b0;
            mismatches        = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SMOOTH_EN:    regs.smooth_en    = val[0];
                CFG_SLOPE:        regs.slope        = val[SLOPE_W-1:0];
                CFG_STALL_MARGIN: regs.stall_margin = val[MARGIN_W-1:0];
                CFG_GRIP_MARGIN:  regs.grip_margin  = val[MARGIN_W-1:0];
                CFG_RUN_LIMIT:    regs.run_limit    = val[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // One accepted sample: advance the state and queue its result
        function void note_sample(logic [LOAD_W-1:0] load, logic [VEL_W-1:0] vel,
                                  logic grip);
            logic [31:0]         acc;
            logic [MARGIN_W-1:0] margin;
            longint              compared;
            longint              thr;
            bit                  stop;
            t_result             r;
            compared = longint'(load);
            stop     = 1'b0;
            if (regs.smooth_en) begin
                acc      = (32'(load) << EMA_FRAC) + 32'(ema) * 32'd3;
                ema      = EMA_W'(acc >> 2);
                compared = longint'(ema >> EMA_FRAC);
                if (grip)
                    grip_latched = 1'b1;
            end
            margin = grip_latched ? regs.grip_margin : regs.stall_margin;
            thr = longint'((32'(regs.slope) * 32'(vel)) >> SLOPE_FRAC) - longint'(margin);
            if (compared < thr) begin
                run_cnt = run_cnt + 1'b1;
                if (run_cnt >= regs.run_limit) begin
                    stop       = 1'b1;
                    stall_seen = 1'b1;
                    run_cnt    = '0;
                end
            end else begin
                run_cnt = '0;
            end
            r.stop  = stop;
            r.stall = stall_seen;
            r.count = run_cnt;
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data);
            t_result got;
            t_result want;
            got.stop  = data[0];
            got.stall = data[1];
            got.count = data[9:2];
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result transfer: stop=%0d stall=%0d count=%0d",
                             got.stop, got.stall, got.count);
                return;
            end
            want = expected_results.pop_front();
            if (got.stop !== want.stop || got.stall !== want.stall
                    || got.count !== want.count) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: expected stop=%0d stall=%0d count=%0d, got stop=%0d stall=%0d count=%0d",
                             want.stop, want.stall, want.count,
                             got.stop, got.stall, got.count);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function bit failed();
            return mismatches > 0 || expected_results.size() > 0;
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    stall_tracker tracker;
    bit           send_idle   = 1'b1;
    bit           recv_idle   = 1'b1;
    int           hold_cycles = 0;
    int           cycle_count = 0;

    load_stall_detector #(
        .SMOOTH_FRAC_BITS(EMA_FRAC)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Write one register; the caller owns the write enable
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        tracker.set_reg(idx, val);
    endtask

    task automatic apply_config(t_cfg c);
        i_cfg_we <= 1'b1;
        write_reg(CFG_SMOOTH_EN, CFG_DATA_W'(c.smooth_en));
        write_reg(CFG_SLOPE, CFG_DATA_W'(c.slope));
        write_reg(CFG_STALL_MARGIN, CFG_DATA_W'(c.stall_margin));
        write_reg(CFG_GRIP_MARGIN, CFG_DATA_W'(c.grip_margin));
        write_reg(CFG_RUN_LIMIT, CFG_DATA_W'(c.run_limit));
        i_cfg_we <= 1'b0;
    endtask

    // Offer one sample and wait for its transfer; tvalid stays high on return
    task automatic send_sample(logic [LOAD_W-1:0] load, logic [VEL_W-1:0] vel,
                               logic grip);
        int gap;
        gap = send_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({vel, load});
        s_axis_tuser  <= grip;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.note_sample(load, vel, grip);
    endtask

    // Stop offering and wait until every queued result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Result side: random or requested stalls, one check per transfer
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = recv_idle ? $urandom_range(0, 9) : 0;
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            tracker.check_result(m_axis_tdata);
        end
    end

    initial begin
        t_cfg             cfg;
        int               phase;
        int               sent;
        int               n_items;
        int               burst_left;
        bit               low_burst;
        longint           knee;
        logic [LOAD_W-1:0] load;
        logic [VEL_W-1:0] vel;
        logic             grip;

        tracker = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults: raw compare against velocity, run limit of three
        send_sample(10'd0, 16'd0, 1'b0);
        send_sample(10'd1023, 16'd0, 1'b0);
        send_sample(10'd0, 16'd65535, 1'b0);
        send_sample(10'd1023, 16'd65535, 1'b1);   // grip with smoothing off
        send_sample(10'd512, 16'd1023, 1'b0);     // third low sample stops
        send_sample(10'd1023, 16'd1023, 1'b0);    // equal to threshold
        send_sample(10'd1022, 16'd1023, 1'b0);
        send_sample(10'd1023, 16'd1023, 1'b0);
        drain();

        // Large margin gives negative thresholds; unit run limit
        apply_config('{smooth_en: 1'b0, slope: 16'd256, stall_margin: 10'd1023,
                       grip_margin: 10'd0, run_limit: 8'd1});
        send_sample(10'd0, 16'd0, 1'b0);
        send_sample(10'd0, 16'd1023, 1'b0);       // threshold exactly zero
        send_sample(10'd0, 16'd1024, 1'b0);
        send_sample(10'd1023, 16'd65535, 1'b1);
        drain();

        // Zero run limit: every low sample stops at once
        apply_config('{smooth_en: 1'b0, slope: 16'd65535, stall_margin: 10'd0,
                       grip_margin: 10'd1023, run_limit: 8'd0});
        send_sample(10'd0, 16'd1, 1'b0);
        send_sample(10'd1023, 16'd0, 1'b1);
        send_sample(10'd0, 16'd65535, 1'b0);
        drain();

        // Smoothing on, grip held low so the margin latch stays clear
        apply_config('{smooth_en: 1'b1, slope: 16'd256, stall_margin: 10'd0,
                       grip_margin: 10'd1023, run_limit: 8'd2});
        send_sample(10'd1023, 16'd0, 1'b0);
        send_sample(10'd1023, 16'd300, 1'b0);
        send_sample(10'd1023, 16'd700, 1'b0);
        send_sample(10'd0, 16'd65535, 1'b0);
        send_sample(10'd0, 16'd0, 1'b0);
        send_sample(10'd1023, 16'd1023, 1'b0);
        send_sample(10'd1023, 16'd1023, 1'b0);
        send_sample(10'd1023, 16'd1023, 1'b0);
        drain();

        // Random phases, each with its own register setting
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            cfg.smooth_en    = $urandom_range(0, 1);
            cfg.slope        = $urandom_range(0, 3) == 0 ? 16'd65535 : 16'($urandom);
            cfg.stall_margin = $urandom_range(0, 3) == 0 ? 10'd0 : 10'($urandom);
            cfg.grip_margin  = $urandom_range(0, 3) == 0 ? 10'd1023 : 10'($urandom);
            cfg.run_limit    = 8'($urandom_range(1, 12));
            n_items          = 45;
            case (phase)
                0: begin
                    cfg = '{smooth_en: 1'b1, slope: 16'd65535, stall_margin: 10'd1023,
                            grip_margin: 10'd0, run_limit: 8'd255};
                    n_items = 270;
                end
                1: cfg = '{smooth_en: 1'b0, slope: 16'd0, stall_margin: 10'd0,
                           grip_margin: 10'd0, run_limit: 8'd1};
                2: begin
                    cfg.smooth_en = 1'b0;
                    cfg.run_limit = 8'd0;
                end
                4: cfg.smooth_en = 1'b1;
                default: ;
            endcase
            apply_config(cfg);
            send_idle = $urandom_range(0, 3) != 0;
            recv_idle = $urandom_range(0, 3) != 0;
            // Long result stall while samples keep coming back to back
            if (phase == 2) begin
                send_idle   = 1'b0;
                hold_cycles = 40;
            end

            // Velocity where the scaled threshold sits near mid-scale
            if (cfg.slope == 0)
                knee = 65535;
            else
                knee = ((500 + longint'(cfg.stall_margin)) * 256) / cfg.slope;

            burst_left = 0;
            low_burst  = 1'b0;
            for (int n = 0; n < n_items; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, int'(cfg.run_limit) + 2);
                    low_burst  = $urandom_range(0, 1);
                end
                burst_left--;
                if ($urandom_range(0, 9) == 0) begin
                    load = 10'($urandom);
                    vel  = 16'($urandom);
                end else begin
                    load = low_burst ? 10'($urandom_range(0, 350))
                                     : 10'($urandom_range(650, 1023));
                    vel  = (knee + 64 > 65535) ? 16'd65535
                                               : 16'(knee + $urandom_range(0, 64));
                end
                grip = $urandom_range(0, 1);
                // keep the grip latch clear through the early phases
                if (phase < 4 && cfg.smooth_en)
                    grip = 1'b0;
                if (phase == 4 && n == 0)
                    grip = 1'b1;
                send_sample(load, vel, grip);
            end
            sent += n_items;
            drain();
            phase++;
        end

        if (!tracker.failed())
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
